### rtl/dpq_pkg.sv
// Shared types and constants for the descriptor pool free list and queue unit.
// Holds pool geometry, operation and slot-state codes, and channel structs.
// No dependencies.
package dpq_pkg;

  // Pool geometry
  localparam int POOL_DEPTH = 16;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int LINK_W     = $clog2(POOL_DEPTH + 1);

  // Null link is encoded as one past the last slot
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_DEPTH);

  // Field widths of the channels and the configuration register
  localparam int OP_W    = 3;
  localparam int NODE_W  = 4;
  localparam int SIZE_W  = 5;
  localparam int STATE_W = 2;

  localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 5'd16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
  localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd1;
  localparam logic [OP_W-1:0] OP_SUBMIT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP     = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

  // Slot state codes
  localparam logic [STATE_W-1:0] ST_FREE   = 2'd0;
  localparam logic [STATE_W-1:0] ST_ALLOC  = 2'd1;
  localparam logic [STATE_W-1:0] ST_QUEUED = 2'd2;
  localparam logic [STATE_W-1:0] ST_EXEC   = 2'd3;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_index;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic [NODE_W-1:0]  slot_out;
    logic [STATE_W-1:0] slot_state;
  } rsp_t;

  // Link memory access from the controller
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

endpackage

### rtl/dpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/dpq_ctrl.sv
// Sequencer for the descriptor pool: list heads, init sweep and result register.
// Drives the link memory through a ram_req_t; depends on dpq_pkg.
module dpq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  dpq_pkg::cmd_t             cmd,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output dpq_pkg::rsp_t             rsp,
  input  logic [dpq_pkg::SIZE_W-1:0] pool_size,
  output dpq_pkg::ram_req_t         ram_req,
  input  logic [dpq_pkg::LINK_W-1:0] ram_rdata
);
  import dpq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_LINK = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_DEPTH - 1);
  localparam logic [LINK_W-1:0] INIT_N_RST =
    (32'(POOL_SIZE_RST) > POOL_DEPTH) ? NIL_LINK : LINK_W'(POOL_SIZE_RST);

  function automatic logic link_is_slot(input logic [LINK_W-1:0] l);
    return l < NIL_LINK;
  endfunction

  logic [1:0]        state, state_next;
  logic [OP_W-1:0]   op_r, op_r_next;
  logic [SLOT_W-1:0] slot_r, slot_r_next;
  logic [SLOT_W-1:0] idx, idx_next;
  logic [LINK_W-1:0] init_n, init_n_next;
  logic              init_rsp, init_rsp_next;
  logic [LINK_W-1:0] free_head, free_head_next;
  logic [LINK_W-1:0] queue_head, queue_head_next;
  logic [LINK_W-1:0] queue_tail, queue_tail_next;
  rsp_t              rsp_next;
  logic              rsp_load;

  logic              accept;
  logic              node_ok;
  logic [SLOT_W-1:0] node_slot;
  logic [LINK_W-1:0] size_sat;
  logic [LINK_W-1:0] init_link;

  // Take a transaction only when idle and the result register frees up
  assign cmd_stall = !((state == S_IDLE) && (!rsp_valid || !rsp_stall));
  assign accept    = cmd_valid && !cmd_stall;

  assign node_ok   = 32'(cmd.node_index) < POOL_DEPTH;
  assign node_slot = SLOT_W'(cmd.node_index);
  assign size_sat  = (32'(pool_size) > POOL_DEPTH) ? NIL_LINK : LINK_W'(pool_size);
  assign init_link = ((LINK_W'(idx) + LINK_W'(1)) < init_n) ?
                     (LINK_W'(idx) + LINK_W'(1)) : NIL_LINK;

  // Next-state and memory access
  always_comb begin
    state_next      = state;
    op_r_next       = op_r;
    slot_r_next     = slot_r;
    idx_next        = idx;
    init_n_next     = init_n;
    init_rsp_next   = init_rsp;
    free_head_next  = free_head;
    queue_head_next = queue_head;
    queue_tail_next = queue_tail;
    rsp_load        = 1'b0;
    rsp_next        = '0;
    ram_req.we      = 1'b0;
    ram_req.waddr   = '0;
    ram_req.wdata   = NIL_LINK;
    ram_req.raddr   = SLOT_W'(free_head);

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_r_next = cmd.op;
          case (cmd.op)
            OP_INIT: begin
              state_next    = S_INIT;
              idx_next      = '0;
              init_n_next   = size_sat;
              init_rsp_next = 1'b1;
            end
            OP_ACQUIRE: begin
              if (link_is_slot(free_head)) begin
                ram_req.raddr = SLOT_W'(free_head);
                slot_r_next   = SLOT_W'(free_head);
                state_next    = S_READ;
              end else begin
                rsp_load        = 1'b1;
                rsp_next.status = STATUS_EMPTY;
              end
            end
            OP_SUBMIT: begin
              rsp_load          = 1'b1;
              rsp_next.slot_out = cmd.node_index;
              if (node_ok) begin
                // Terminate the new slot first, then hook it behind the tail
                ram_req.we    = 1'b1;
                ram_req.waddr = node_slot;
                ram_req.wdata = NIL_LINK;
                slot_r_next   = node_slot;
                if (link_is_slot(queue_tail)) begin
                  rsp_load   = 1'b0;
                  state_next = S_LINK;
                end else begin
                  queue_head_next     = LINK_W'(node_slot);
                  queue_tail_next     = LINK_W'(node_slot);
                  rsp_next.slot_state = ST_QUEUED;
                end
              end
            end
            OP_POP: begin
              if (link_is_slot(queue_head)) begin
                ram_req.raddr = SLOT_W'(queue_head);
                slot_r_next   = SLOT_W'(queue_head);
                state_next    = S_READ;
              end else begin
                rsp_load        = 1'b1;
                rsp_next.status = STATUS_EMPTY;
              end
            end
            OP_RELEASE: begin
              rsp_load          = 1'b1;
              rsp_next.slot_out = cmd.node_index;
              if (node_ok) begin
                ram_req.we          = 1'b1;
                ram_req.waddr       = node_slot;
                ram_req.wdata       = free_head;
                free_head_next      = LINK_W'(node_slot);
                rsp_next.slot_state = ST_FREE;
              end
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        // Link of the removed head is back; unlink it and advance the list
        ram_req.we        = 1'b1;
        ram_req.waddr     = slot_r;
        ram_req.wdata     = NIL_LINK;
        rsp_load          = 1'b1;
        rsp_next.slot_out = NODE_W'(slot_r);
        state_next        = S_IDLE;
        if (op_r == OP_POP) begin
          queue_head_next     = ram_rdata;
          rsp_next.slot_state = ST_EXEC;
          if (!link_is_slot(ram_rdata)) begin
            queue_tail_next = NIL_LINK;
          end
        end else begin
          free_head_next      = ram_rdata;
          rsp_next.slot_state = ST_ALLOC;
        end
      end

      S_LINK: begin
        // Point the old tail at the submitted slot
        ram_req.we          = 1'b1;
        ram_req.waddr       = SLOT_W'(queue_tail);
        ram_req.wdata       = LINK_W'(slot_r);
        queue_tail_next     = LINK_W'(slot_r);
        rsp_load            = 1'b1;
        rsp_next.slot_out   = NODE_W'(slot_r);
        rsp_next.slot_state = ST_QUEUED;
        state_next          = S_IDLE;
      end

      S_INIT: begin
        // Chain one slot per cycle
        ram_req.we    = 1'b1;
        ram_req.waddr = idx;
        ram_req.wdata = init_link;
        if (idx == LAST_SLOT) begin
          free_head_next  = (init_n != '0) ? '0 : NIL_LINK;
          queue_head_next = NIL_LINK;
          queue_tail_next = NIL_LINK;
          rsp_load        = init_rsp;
          state_next      = S_IDLE;
        end else begin
          idx_next = idx + SLOT_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      idx        <= '0;
      init_n     <= INIT_N_RST;
      init_rsp   <= 1'b0;
      free_head  <= '0;
      queue_head <= NIL_LINK;
      queue_tail <= NIL_LINK;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      init_n     <= init_n_next;
      init_rsp   <= init_rsp_next;
      free_head  <= free_head_next;
      queue_head <= queue_head_next;
      queue_tail <= queue_tail_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r   <= op_r_next;
    slot_r <= slot_r_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

### rtl/descriptor_pool_free_list_and_queue_unit.sv
// Descriptor pool top level: pool size register, link memory and sequencer.
// Depends on dpq_pkg, dpq_ram and dpq_ctrl.
//
// Usage:
//   The cmd channel (cmd_valid/cmd_stall/cmd) carries one operation per
//   transaction: init, acquire, submit, pop or release. The rsp channel
//   (rsp_valid/rsp_stall/rsp) returns exactly one result per command.
//   cfg_write/cfg_data load pool_size, used by the next init.
//   One command is in flight at a time. Release, empty-list cases, slots
//   outside the pool and undefined codes finish in the accepting cycle.
//   Acquire and pop take a link memory read, then the unlink write.
//   Submit behind a non-empty queue adds the S_LINK state, since both the
//   new slot and the old tail take a link write through the single write
//   port. Init sweeps the link memory one slot a cycle over all POOL_DEPTH
//   slots, then gives the result.
//   After reset the same sweep runs with pool size 16 (no result);
//   cmd_stall stays high meanwhile.
//   The result register holds while rsp_stall is high; a new command is
//   taken in the cycle its result register is drained.
module descriptor_pool_free_list_and_queue_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  dpq_pkg::cmd_t              cmd,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output dpq_pkg::rsp_t              rsp,
  input  logic                       cfg_write,
  input  logic [dpq_pkg::SIZE_W-1:0] cfg_data
);
  import dpq_pkg::*;

  logic [SIZE_W-1:0] pool_size;
  ram_req_t          ram_req;
  logic [LINK_W-1:0] ram_rdata;

  // Pool size register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= POOL_SIZE_RST;
    end else if (cfg_write) begin
      pool_size <= cfg_data;
    end
  end

  // Per-slot link memory
  dpq_ram #(
    .WIDTH(LINK_W),
    .DEPTH(POOL_DEPTH)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  // Sequencer
  dpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .pool_size(pool_size),
    .ram_req  (ram_req),
    .ram_rdata(ram_rdata)
  );

endmodule
